@@ rtl/lse_pkg.sv @@
`default_nettype none

package lse_pkg;

  // End marker that closes the hidden message
  localparam logic [7:0] END_MARKER = 8'h07;

  typedef enum logic {
    KIND_MESSAGE = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_MISMATCH   = 2'd1,
    STATUS_NO_CHECK   = 2'd2,
    STATUS_NO_MARKER  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  message_byte;
    status_t     status;
    logic [7:0]  stored_checksum;
    logic        computed_checksum;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/lse_core.sv @@
`default_nettype none

module lse_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire                 cover_bit,
  input  wire                 last_component,
  output logic                res_valid,
  output lse_pkg::result_t    res
);

  logic [6:0] partial_bits;
  logic [2:0] bit_position;
  logic [7:0] held_byte;
  logic       held_present;
  logic       running_parity;
  logic       frame_done;

  logic [6:0] partial_bits_next;
  logic [2:0] bit_position_next;
  logic [7:0] held_byte_next;
  logic       held_present_next;
  logic       running_parity_next;
  logic       frame_done_next;
  logic       clear;
  logic [7:0] full_byte;

  assign full_byte = {partial_bits, cover_bit};

  always_comb begin
    partial_bits_next   = partial_bits;
    bit_position_next   = bit_position;
    held_byte_next      = held_byte;
    held_present_next   = held_present;
    running_parity_next = running_parity;
    frame_done_next     = frame_done;
    clear               = 1'b0;
    res_valid           = 1'b0;
    res.kind              = lse_pkg::KIND_REPORT;
    res.message_byte      = 8'd0;
    res.status            = lse_pkg::STATUS_OK;
    res.stored_checksum   = 8'd0;
    res.computed_checksum = running_parity;

    if (accept) begin
      if (frame_done) begin
        // wait out the rest of the image
        clear = last_component;
      end else if (bit_position != 3'd7) begin
        partial_bits_next = {partial_bits[5:0], cover_bit};
        bit_position_next = bit_position + 3'd1;
        if (last_component) begin
          res_valid  = 1'b1;
          res.status = lse_pkg::STATUS_NO_MARKER;
          clear      = 1'b1;
        end
      end else begin
        partial_bits_next = 7'd0;
        bit_position_next = 3'd0;
        if (full_byte == lse_pkg::END_MARKER) begin
          res_valid = 1'b1;
          if (held_present) begin
            res.status = (held_byte == {7'd0, running_parity}) ?
                         lse_pkg::STATUS_OK : lse_pkg::STATUS_MISMATCH;
            res.stored_checksum = held_byte;
          end else begin
            res.status = lse_pkg::STATUS_NO_CHECK;
          end
          frame_done_next = 1'b1;
          clear           = last_component;
        end else if (last_component) begin
          // drop any held byte
          res_valid  = 1'b1;
          res.status = lse_pkg::STATUS_NO_MARKER;
          clear      = 1'b1;
        end else if (held_present) begin
          res_valid             = 1'b1;
          res.kind              = lse_pkg::KIND_MESSAGE;
          res.message_byte      = held_byte;
          res.computed_checksum = 1'b0;
          running_parity_next   = running_parity ^ (^held_byte);
          held_byte_next        = full_byte;
        end else begin
          held_byte_next    = full_byte;
          held_present_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      partial_bits   <= 7'd0;
      bit_position   <= 3'd0;
      held_byte      <= 8'd0;
      held_present   <= 1'b0;
      running_parity <= 1'b0;
      frame_done     <= 1'b0;
    end else begin
      partial_bits   <= partial_bits_next;
      bit_position   <= bit_position_next;
      held_byte      <= held_byte_next;
      held_present   <= held_present_next;
      running_parity <= running_parity_next;
      frame_done     <= frame_done_next;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_done) |-> !res_valid)
    else $error("result produced after final report");

  a_msg_needs_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == lse_pkg::KIND_MESSAGE) |-> (held_present && bit_position == 3'd7))
    else $error("message byte without a held byte");

  a_check_needs_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == lse_pkg::STATUS_OK || res.status == lse_pkg::STATUS_MISMATCH)
     && res.kind == lse_pkg::KIND_REPORT) |-> held_present)
    else $error("checksum report without stored checksum");

endmodule

`default_nettype wire

@@ rtl/lsb_stego_extractor.sv @@
// A result is registered into the output register, or into the skid register while the output is stalled.
// Throughput: one component word per cycle while s_tready is high; each word needs one shift,
// one marker compare and one parity update, all in the combinational logic of lse_core.
// A two-entry output buffer (register plus skid) keeps s_tready high while only one result waits.
// Reset (rst, synchronous, active high) clears the frame state and empties the buffer.
`default_nettype none

module lsb_stego_extractor (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] cover_component
  input  wire         s_tlast,   // last_component
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // [7:0] message_byte, [9:8] status,
                                 // [17:10] stored_checksum, [18] computed_checksum, rest 0
  output logic [0:0]  m_tuser    // item_kind
);

  logic              accept;
  logic              res_valid;
  lse_pkg::result_t  res;

  // output register and skid stage
  lse_pkg::result_t  main_word;
  lse_pkg::result_t  skid_word;
  logic              main_valid;
  logic              skid_valid;
  logic              main_free;

  // Accept whenever the skid stage is empty; a stalled output still has room for one word.
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // Only bit 0 of the component carries message data.
  lse_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cover_bit      (s_tdata[0]),
    .last_component (s_tlast),
    .res_valid      (res_valid),
    .res            (res)
  );

  assign main_free = !main_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      // advance: skid word first, else the fresh result
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= res_valid;
      end
    end else if (res_valid) begin
      // hold the stalled word, park the new one
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_word <= skid_valid ? skid_word : res;
    end
    if (!main_free && res_valid) begin
      skid_word <= res;
    end
  end

  assign m_tvalid = main_valid;
  assign m_tuser  = main_word.kind;
  assign m_tdata  = {5'd0, main_word.computed_checksum, main_word.stored_checksum,
                     main_word.status, main_word.message_byte};

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid word without output word");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !accept)
    else $error("word accepted with buffer full");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> (main_valid && !skid_valid))
    else $error("skid word not advanced");

endmodule

`default_nettype wire

@@ tb/lsb_stego_extractor_test.sv @@
module lsb_stego_extractor_test;

  // Predict the extractor: rebuild bytes from component LSBs, hold one byte back,
  // and queue the message words and status reports that the block should emit.
  class stego_scoreboard;
    logic [6:0]        shift_bits;
    logic [2:0]        bit_count;
    logic [7:0]        pending_byte;
    logic              pending_valid;
    logic              parity;
    logic              frame_closed;
    lse_pkg::result_t  expected_q[$];
    int                errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      shift_bits    = '0;
      bit_count     = '0;
      pending_byte  = '0;
      pending_valid = 1'b0;
      parity        = 1'b0;
      frame_closed  = 1'b0;
    endfunction

    function void push_report(lse_pkg::status_t st, logic [7:0] stored);
      lse_pkg::result_t r;
      r.kind              = lse_pkg::KIND_REPORT;
      r.message_byte      = 8'h00;
      r.status            = st;
      r.stored_checksum   = stored;
      r.computed_checksum = parity;
      expected_q.push_back(r);
    endfunction

    // Note one accepted component word.
    function void note_component(logic [7:0] comp, logic is_last);
      logic [7:0]       assembled;
      lse_pkg::result_t r;
      if (frame_closed) begin
        if (is_last) clear_frame();
        return;
      end
      if (bit_count != 3'd7) begin
        shift_bits = {shift_bits[5:0], comp[0]};
        bit_count  = bit_count + 3'd1;
        if (is_last) begin
          push_report(lse_pkg::STATUS_NO_MARKER, 8'h00);
          clear_frame();
        end
        return;
      end
      assembled  = {shift_bits, comp[0]};
      shift_bits = '0;
      bit_count  = '0;
      if (assembled == lse_pkg::END_MARKER) begin
        if (pending_valid)
          push_report((pending_byte == {7'b0, parity}) ?
                      lse_pkg::STATUS_OK : lse_pkg::STATUS_MISMATCH, pending_byte);
        else
          push_report(lse_pkg::STATUS_NO_CHECK, 8'h00);
        frame_closed = 1'b1;
        if (is_last) clear_frame();
        return;
      end
      if (is_last) begin
        // drop the held byte, no marker seen
        push_report(lse_pkg::STATUS_NO_MARKER, 8'h00);
        clear_frame();
        return;
      end
      if (pending_valid) begin
        r.kind              = lse_pkg::KIND_MESSAGE;
        r.message_byte      = pending_byte;
        r.status            = lse_pkg::STATUS_OK;
        r.stored_checksum   = 8'h00;
        r.computed_checksum = 1'b0;
        expected_q.push_back(r);
        parity = parity ^ (^pending_byte);
      end
      pending_byte  = assembled;
      pending_valid = 1'b1;
    endfunction

    // Check one accepted result word against the oldest expectation.
    function void check_result(logic [23:0] data, logic [0:0] user);
      lse_pkg::result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected result: tuser %0d tdata %h", user, data);
        return;
      end
      want = expected_q.pop_front();
      if (user[0] !== want.kind) begin
        errors++;
        $error("item_kind: expected %0d, actual %0d", want.kind, user[0]);
      end
      if (data[7:0] !== want.message_byte) begin
        errors++;
        $error("message_byte: expected %h, actual %h", want.message_byte, data[7:0]);
      end
      if (data[9:8] !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, data[9:8]);
      end
      if (data[17:10] !== want.stored_checksum) begin
        errors++;
        $error("stored_checksum: expected %h, actual %h", want.stored_checksum, data[17:10]);
      end
      if (data[18] !== want.computed_checksum) begin
        errors++;
        $error("computed_checksum: expected %0d, actual %0d", want.computed_checksum, data[18]);
      end
      if (data[23:19] !== 5'b0) begin
        errors++;
        $error("tdata padding: expected 0, actual %h", data[23:19]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] cover_component
  logic        s_tlast  = 1'b0;    // last_component
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;            // [7:0] message_byte, [9:8] status,
                                   // [17:10] stored_checksum, [18] computed_checksum
  logic [0:0]  m_tuser;            // item_kind

  stego_scoreboard sb = new();
  bit              calm = 1'b0;    // set to hold both sides free of idling
  int              words_sent = 0;

  lsb_stego_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Send one component word; optionally idle first, then hold until accepted.
  task automatic send_word(input logic [7:0] comp, input logic is_last);
    if (!calm && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(0, 255));
      @(posedge clk);
      while ($urandom_range(0, 99) < 50) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= comp;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_component(comp, is_last);
  endtask

  // Hide one byte in eight components, MSB first; fill < 0 randomizes the upper bits.
  task automatic send_byte(input logic [7:0] value, input logic is_last, input int fill);
    logic [6:0] upper;
    for (int i = 7; i >= 0; i--) begin
      upper = (fill < 0) ? 7'($urandom_range(0, 127)) : fill[6:0];
      send_word({upper, value[i]}, is_last && (i == 0));
    end
    words_sent += 8;
  endtask

  function automatic logic [7:0] random_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == lse_pkg::END_MARKER);
    return b;
  endfunction

  // Message, an optional checksum and the marker, then an optional tail of ignored components up to the last.
  task automatic send_framed_message();
    int         count;
    int         mode;
    int         tail;
    logic [7:0] b;
    logic       par;
    count = $urandom_range(0, 5);
    mode  = $urandom_range(0, 9);
    tail  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
    par   = 1'b0;
    for (int i = 0; i < count; i++) begin
      b   = random_text_byte();
      par = par ^ (^b);
      send_byte(b, 1'b0, -1);
    end
    if (mode < 5)      send_byte({7'b0, par}, 1'b0, -1);
    else if (mode < 7) send_byte({7'b0, ~par}, 1'b0, -1);
    else if (mode < 9) send_byte(random_text_byte(), 1'b0, -1);
    send_byte(lse_pkg::END_MARKER, tail == 0, -1);
    for (int i = 0; i < tail; i++)
      send_word(8'($urandom_range(0, 255)), i == tail - 1);
    words_sent += tail;
  endtask

  // Whole bytes with no marker, then a partial byte if any; the last component ends the final part.
  task automatic send_unmarked_message();
    int         count;
    int         bits;
    logic [7:0] b;
    count = $urandom_range(0, 4);
    bits  = $urandom_range((count == 0) ? 1 : 0, 7);
    for (int i = 0; i < count; i++) begin
      b = random_text_byte();
      send_byte(b, (bits == 0) && (i == count - 1), -1);
    end
    for (int i = 0; i < bits; i++)
      send_word(8'($urandom_range(0, 255)), i == bits - 1);
    words_sent += bits;
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 40);
    for (int i = 0; i < n; i++)
      send_word(8'($urandom_range(0, 255)), i == n - 1);
    words_sent += n;
  endtask

  // Accept results and drive m_tready; check only after reset.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_result(m_tdata, m_tuser);
      m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end
  end

  initial begin
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Marker as the first byte: no checksum in front of it, on the last component.
    send_byte(lse_pkg::END_MARKER, 1'b1, 127);
    // Last component in the middle of a byte: no marker.
    send_word(8'h01, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h01, 1'b1);
    // Checksum zero over an empty message, marker completed on the last component.
    send_byte(8'h00, 1'b0, 0);
    send_byte(lse_pkg::END_MARKER, 1'b1, 0);

    words_sent = 0;
    while (words_sent < 1500) begin
      calm = (words_sent >= 600) && (words_sent < 900);
      pick = $urandom_range(0, 99);
      if (pick < 70)      send_framed_message();
      else if (pick < 85) send_unmarked_message();
      else                send_noise();
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    // Drain, then wait for stray results.
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lse_pkg.sv
rtl/lse_core.sv
rtl/lsb_stego_extractor.sv
tb/lsb_stego_extractor_test.sv
